/* src/token_bucket_rate_limiter_macros.svh */
// assertion macros shared by the rate limiter rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef TOKEN_BUCKET_RATE_LIMITER_MACROS_SVH
`define TOKEN_BUCKET_RATE_LIMITER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TBRL_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tbrl assertion failed");

// next-cycle implication
`define TBRL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tbrl assertion failed");

`else

`define TBRL_ASSERT_IMPL(label, ante, cons)
`define TBRL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* src/tbrl_pkg.sv */
// widths, codes and divider interface types of the token bucket rate limiter
// no dependencies
package tbrl_pkg;

	localparam int ACTION_W   = 2;
	localparam int AMOUNT_W   = 24;
	localparam int MAXWAIT_W  = 16;
	localparam int STATUS_W   = 3;
	localparam int TICKS_W    = 32;
	localparam int TOKENS_W   = 32;
	localparam int RATE_W     = 24;
	localparam int CAP_W      = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// dividend is shortfall plus divisor minus one, one bit wider than the shortfall
	localparam int DIVIDEND_W = TICKS_W + 1;
	localparam int DIV_STEPS  = DIVIDEND_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [CAP_W-1:0]  CAP_RESET = 24'd1024;
	localparam logic [RATE_W-1:0] RATE_MIN  = 24'd1;

	localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CONSUME = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_NONE       = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_GRANTED    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_DENIED     = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_WAITING    = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_BUSY       = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_PEND_GRANT = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd1;

	typedef struct packed {
		logic               start;
		logic [TICKS_W-1:0] shortfall;
		logic [RATE_W-1:0]  rate;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [TICKS_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* src/tbrl_div.sv */
// bit-serial restoring divider: ceil(shortfall / rate), saturated to the wait width
// depends on tbrl_pkg
module tbrl_div (
	input  logic                clk,
	input  logic                arst_n,
	input  tbrl_pkg::div_req_t  req,
	output tbrl_pkg::div_rsp_t  rsp
);
	import tbrl_pkg::*;

	logic                  busy_q;
	logic                  prep_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [RATE_W-1:0]     divisor_q;
	logic [RATE_W-1:0]     rem_q;
	logic [DIVIDEND_W-1:0] dq_q;

	logic [RATE_W:0]       rem_sh;
	logic [RATE_W+1:0]     trial;
	logic                  q_bit;

	// remainder stays below the divisor, so the shifted value fits one extra bit
	assign rem_sh = {rem_q, dq_q[DIVIDEND_W-1]};
	assign trial  = {1'b0, rem_sh} - {2'b0, divisor_q};
	assign q_bit  = !trial[RATE_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			prep_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				prep_q <= 1'b1;
				cnt_q  <= '0;
			end else if (prep_q) begin
				prep_q <= 1'b0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
				end
			end
		end
	end

	// dividend holds the remaining dividend bits on top, quotient bits shift in below
	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q      <= {1'b0, req.shortfall};
			divisor_q <= req.rate;
		end else if (prep_q) begin
			// bias for the ceiling
			dq_q  <= dq_q + DIVIDEND_W'(divisor_q) - DIVIDEND_W'(1);
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= q_bit ? trial[RATE_W-1:0] : rem_sh[RATE_W-1:0];
			dq_q  <= {dq_q[DIVIDEND_W-2:0], q_bit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q[DIVIDEND_W-1] ? '1 : dq_q[TICKS_W-1:0];

endmodule

/* src/token_bucket_rate_limiter.sv */
// token bucket rate limiter top level: bucket state, item sequencing, output register
// depends on tbrl_pkg, tbrl_div and token_bucket_rate_limiter_macros.svh
//
// Token bucket with a signed 32-bit token count. Each accepted input beat (tick, request or
// consume) produces exactly one output beat carrying status, wait_ticks and tokens_now. Items
// are handled one at a time: a consume, a request without shortfall or the unused action code
// goes straight to the stage register, a tick is staged after its refill and then the retry of
// a pending consume, and a request that leaves the count negative is staged once the bit-serial
// divider is done, which forms the wait with one quotient bit per cycle over a 33-bit dividend. A finished result
// then moves to the output register, after which the next item is taken while that result
// waits for the consumer. cfg_ready is always high; write configuration only while the block
// is idle. Writing capacity refills the bucket; a rate of zero is held as one.
`include "token_bucket_rate_limiter_macros.svh"

module token_bucket_rate_limiter (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [tbrl_pkg::ACTION_W-1:0]     action,
	input  logic [tbrl_pkg::AMOUNT_W-1:0]     amount,
	input  logic [tbrl_pkg::MAXWAIT_W-1:0]    max_wait,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tbrl_pkg::STATUS_W-1:0]     status,
	output logic [tbrl_pkg::TICKS_W-1:0]      wait_ticks,
	output logic signed [tbrl_pkg::TOKENS_W-1:0] tokens_now,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tbrl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tbrl_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tbrl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_TICK = 3'b010,
		ST_DIV  = 3'b100
	} state_t;

	state_t                  state_q;
	logic [CAP_W-1:0]        cap_q;
	logic [RATE_W-1:0]       rate_q;
	logic [TOKENS_W-1:0]     tc_q;
	logic                    pend_valid_q;
	logic [AMOUNT_W-1:0]     pend_amount_q;
	logic [MAXWAIT_W-1:0]    pend_limit_q;
	logic [MAXWAIT_W-1:0]    pend_elapsed_q;
	logic                    stage_valid_q;
	logic [STATUS_W-1:0]     stage_status_q;
	logic [TICKS_W-1:0]      stage_wait_q;
	logic                    out_valid_q;
	logic [STATUS_W-1:0]     status_q;
	logic [TICKS_W-1:0]      wait_ticks_q;
	logic [TOKENS_W-1:0]     tokens_now_q;

	logic                    in_accept;
	logic                    xfer;
	logic [TOKENS_W:0]       tc_ext;
	logic [TOKENS_W:0]       amt_ext;
	logic [TOKENS_W:0]       diff_take;
	logic [TOKENS_W:0]       short_fall;
	logic                    enough;
	logic [TOKENS_W-1:0]     take_sat;
	logic [TOKENS_W:0]       refill_sum;
	logic                    over_cap;
	logic [TOKENS_W-1:0]     refill_val;
	logic [TOKENS_W:0]       pend_diff;
	logic                    pend_ok;
	logic [MAXWAIT_W-1:0]    elapsed_inc;
	logic                    timeout;
	logic [STATUS_W-1:0]     consume_status;
	logic                    consume_take;
	logic                    consume_hold;

	div_req_t                div_req;
	div_rsp_t                div_rsp;

	assign in_stall  = (state_q != ST_IDLE) || stage_valid_q;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign xfer      = stage_valid_q && (!out_valid_q || !out_stall);

	assign tc_ext     = {tc_q[TOKENS_W-1], tc_q};
	assign amt_ext    = (TOKENS_W+1)'(amount);
	assign diff_take  = tc_ext - amt_ext;
	assign short_fall = amt_ext - tc_ext;
	assign enough     = !diff_take[TOKENS_W];
	// debt saturates at the signed floor
	assign take_sat   = (diff_take[TOKENS_W] && !diff_take[TOKENS_W-1]) ?
		{1'b1, {(TOKENS_W-1){1'b0}}} : diff_take[TOKENS_W-1:0];

	assign refill_sum = tc_ext + (TOKENS_W+1)'(rate_q);
	assign over_cap   = $signed(refill_sum) > $signed((TOKENS_W+1)'(cap_q));
	assign refill_val = over_cap ? TOKENS_W'(cap_q) : refill_sum[TOKENS_W-1:0];

	assign pend_diff   = tc_ext - (TOKENS_W+1)'(pend_amount_q);
	assign pend_ok     = !pend_diff[TOKENS_W];
	assign elapsed_inc = pend_elapsed_q + MAXWAIT_W'(1);
	assign timeout     = elapsed_inc >= pend_limit_q;

	always_comb begin
		consume_take = 1'b0;
		consume_hold = 1'b0;
		if (amount == '0) begin
			consume_status = STAT_GRANTED;
		end else if (pend_valid_q) begin
			consume_status = STAT_BUSY;
		end else if (enough) begin
			consume_status = STAT_GRANTED;
			consume_take   = 1'b1;
		end else if (max_wait == '0) begin
			consume_status = STAT_DENIED;
		end else begin
			consume_status = STAT_WAITING;
			consume_hold   = 1'b1;
		end
	end

	assign div_req.start     = in_accept && (action == ACT_REQUEST) && !enough;
	assign div_req.shortfall = short_fall[TICKS_W-1:0];
	assign div_req.rate      = rate_q;

	tbrl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cap_q         <= CAP_RESET;
			rate_q        <= RATE_MIN;
			tc_q          <= TOKENS_W'(CAP_RESET);
			pend_valid_q  <= 1'b0;
			stage_valid_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CAPACITY: begin
						cap_q <= cfg_data;
						tc_q  <= TOKENS_W'(cfg_data);
					end
					REG_RATE: begin
						rate_q <= (cfg_data == '0) ? RATE_MIN : cfg_data;
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						case (action)
							ACT_TICK: begin
								tc_q    <= refill_val;
								state_q <= ST_TICK;
							end
							ACT_REQUEST: begin
								tc_q <= take_sat;
								if (enough) begin
									stage_valid_q <= 1'b1;
								end else begin
									state_q <= ST_DIV;
								end
							end
							ACT_CONSUME: begin
								if (consume_take) begin
									tc_q <= diff_take[TOKENS_W-1:0];
								end
								if (consume_hold) begin
									pend_valid_q <= 1'b1;
								end
								stage_valid_q <= 1'b1;
							end
							default: begin
								stage_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_TICK: begin
					// retry the pending consume against the refilled count
					if (pend_valid_q) begin
						if (pend_ok) begin
							tc_q         <= pend_diff[TOKENS_W-1:0];
							pend_valid_q <= 1'b0;
						end else if (timeout) begin
							pend_valid_q <= 1'b0;
						end
					end
					stage_valid_q <= 1'b1;
					state_q       <= ST_IDLE;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						stage_valid_q <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (xfer) begin
				stage_valid_q <= 1'b0;
				out_valid_q   <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_accept) begin
			stage_wait_q <= '0;
			case (action)
				ACT_REQUEST: begin
					stage_status_q <= STAT_GRANTED;
				end
				ACT_CONSUME: begin
					stage_status_q <= consume_status;
					if (consume_hold) begin
						pend_amount_q  <= amount;
						pend_limit_q   <= max_wait;
						pend_elapsed_q <= '0;
					end
				end
				default: begin
					stage_status_q <= STAT_NONE;
				end
			endcase
		end

		if (state_q == ST_TICK) begin
			if (!pend_valid_q) begin
				stage_status_q <= STAT_NONE;
			end else if (pend_ok) begin
				stage_status_q <= STAT_PEND_GRANT;
			end else begin
				pend_elapsed_q <= elapsed_inc;
				stage_status_q <= timeout ? STAT_DENIED : STAT_WAITING;
			end
		end

		if (state_q == ST_DIV && div_rsp.done) begin
			stage_wait_q <= div_rsp.quotient;
		end

		// apart from a capacity write, the count cannot move between an item's end and its transfer
		if (xfer) begin
			status_q     <= stage_status_q;
			wait_ticks_q <= stage_wait_q;
			tokens_now_q <= tc_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign wait_ticks = wait_ticks_q;
	assign tokens_now = tokens_now_q;

	`TBRL_ASSERT_IMPL(a_stage_only_when_idle, state_q != ST_IDLE, !stage_valid_q)
	`TBRL_ASSERT_IMPL(a_div_done_in_div, div_rsp.done, state_q == ST_DIV)
	`TBRL_ASSERT_NEXT(a_div_result_staged, (state_q == ST_DIV) && div_rsp.done, stage_valid_q)
	`TBRL_ASSERT_IMPL(a_tokens_within_cap, 1'b1, $signed(tc_q) <= $signed(TOKENS_W'(cap_q)))
	`TBRL_ASSERT_IMPL(a_pending_has_limit, pend_valid_q, pend_limit_q != '0)

endmodule
